>>> hdl/sxi_pkg.sv
// Package: widths, queue sizing and the job record shared by the intersection blocks.
package sxi_pkg;

  localparam int CW = 24;            // coordinate width
  localparam int COORD_FRAC = 12;    // coordinate fraction bits (Q12.12)
  localparam int DW = CW + 1;        // difference width
  localparam int PW = 2 * DW;        // product width
  localparam int SW = PW + 1;        // cross-product sum width
  localparam int TF = 24;            // fraction bits of t
  localparam int TW = TF + 1;        // t including the integer bit
  localparam int MW = DW + TW;       // magnitude times t
  localparam int FIFO_DEPTH = 4;
  localparam int FAW = $clog2(FIFO_DEPTH);
  localparam int FCW = $clog2(FIFO_DEPTH + 1);

  // One classified pair, handed from the front end to the divider side.
  typedef struct packed {
    logic          crossed;
    logic          one;       // tn equals den, so t is exactly one
    logic [SW-1:0] tn;
    logic [SW-1:0] den;
    logic [DW-1:0] magx;
    logic          negx;
    logic [DW-1:0] magy;
    logic          negy;
    logic [CW-1:0] ax0;
    logic [CW-1:0] ay0;
  } sxi_job_t;

  // Queue status toward the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } sxi_qstat_t;

  function automatic logic signed [DW-1:0] sxi_sx(input logic [CW-1:0] a);
    return $signed({a[CW-1], a});
  endfunction

endpackage

>>> hdl/sxi_ifs.sv
// Interfaces: the segment-pair request channel and the result channel.
interface sxi_pair_if;
  import sxi_pkg::*;
  logic          valid;
  logic          ready;
  logic signed [CW-1:0] first_start_x;
  logic signed [CW-1:0] first_start_y;
  logic signed [CW-1:0] first_end_x;
  logic signed [CW-1:0] first_end_y;
  logic signed [CW-1:0] second_start_x;
  logic signed [CW-1:0] second_start_y;
  logic signed [CW-1:0] second_end_x;
  logic signed [CW-1:0] second_end_y;
  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                output ready);
endinterface

interface sxi_result_if;
  import sxi_pkg::*;
  logic          valid;
  logic          ready;
  logic          crossed;
  logic signed [CW-1:0] cross_x;
  logic signed [CW-1:0] cross_y;
  modport source (output valid, crossed, cross_x, cross_y, input ready);
  modport sink (input valid, crossed, cross_x, cross_y, output ready);
endinterface

>>> hdl/sxi_front.sv
// Front end: differences, cross products, sign fix and range classification.
module sxi_front (
  input  logic              clk,
  input  logic              rst,
  sxi_pair_if.sink          pair,
  input  sxi_pkg::sxi_qstat_t qstat,
  output logic              push,
  output sxi_pkg::sxi_job_t job
);
  import sxi_pkg::*;

  logic en;
  logic v1, v2, v3, v4, v5;

  logic signed [DW-1:0] dax1, day1, dbx1, dby1, ox1, oy1;
  logic [CW-1:0] ax0_1, ay0_1;

  logic signed [PW-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [DW-1:0] dax2, day2;
  logic [CW-1:0] ax0_2, ay0_2;

  logic signed [SW-1:0] den3, tn3, un3;
  logic signed [DW-1:0] dax3, day3;
  logic [CW-1:0] ax0_3, ay0_3;

  logic signed [SW-1:0] den4, tn4, un4;
  logic [DW-1:0] magx4, magy4;
  logic negx4, negy4;
  logic [CW-1:0] ax0_4, ay0_4;

  logic ok4;

  assign en = !v5 || !qstat.full;
  assign push = v5 && !qstat.full;
  assign pair.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0; v5 <= 1'b0;
    end else if (en) begin
      v1 <= pair.valid; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4;
    end
  end

  assign ok4 = (den4 != '0) && !tn4[SW-1] && (tn4 <= den4) && !un4[SW-1] && (un4 <= den4);

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: direction vectors and offset
      dax1  <= sxi_sx(pair.first_end_x) - sxi_sx(pair.first_start_x);
      day1  <= sxi_sx(pair.first_end_y) - sxi_sx(pair.first_start_y);
      dbx1  <= sxi_sx(pair.second_end_x) - sxi_sx(pair.second_start_x);
      dby1  <= sxi_sx(pair.second_end_y) - sxi_sx(pair.second_start_y);
      ox1   <= sxi_sx(pair.second_start_x) - sxi_sx(pair.first_start_x);
      oy1   <= sxi_sx(pair.second_start_y) - sxi_sx(pair.first_start_y);
      ax0_1 <= pair.first_start_x;
      ay0_1 <= pair.first_start_y;
      // stage 2: six products side by side
      p1 <= dax1 * dby1;
      p2 <= day1 * dbx1;
      p3 <= ox1 * dby1;
      p4 <= oy1 * dbx1;
      p5 <= ox1 * day1;
      p6 <= oy1 * dax1;
      dax2 <= dax1; day2 <= day1; ax0_2 <= ax0_1; ay0_2 <= ay0_1;
      // stage 3: cross-product sums
      den3 <= SW'(p1) - SW'(p2);
      tn3  <= SW'(p3) - SW'(p4);
      un3  <= SW'(p5) - SW'(p6);
      dax3 <= dax2; day3 <= day2; ax0_3 <= ax0_2; ay0_3 <= ay0_2;
      // stage 4: make den positive, split da into sign and magnitude
      den4  <= den3[SW-1] ? -den3 : den3;
      tn4   <= den3[SW-1] ? -tn3 : tn3;
      un4   <= den3[SW-1] ? -un3 : un3;
      negx4 <= dax3[DW-1];
      negy4 <= day3[DW-1];
      magx4 <= dax3[DW-1] ? DW'(-dax3) : DW'(dax3);
      magy4 <= day3[DW-1] ? DW'(-day3) : DW'(day3);
      ax0_4 <= ax0_3; ay0_4 <= ay0_3;
      // stage 5: range test, queue entry
      job.crossed <= ok4;
      job.one     <= (tn4 == den4);
      job.tn      <= tn4;
      job.den     <= den4;
      job.magx    <= magx4;
      job.negx    <= negx4;
      job.magy    <= magy4;
      job.negy    <= negy4;
      job.ax0     <= ax0_4;
      job.ay0     <= ay0_4;
    end
  end

endmodule

>>> hdl/sxi_fifo.sv
// Short job queue between the front end and the divider side.
module sxi_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sxi_pkg::sxi_job_t   wdata,
  input  logic                pop,
  output sxi_pkg::sxi_job_t   rdata,
  output sxi_pkg::sxi_qstat_t qstat
);
  import sxi_pkg::*;

  sxi_job_t mem [FIFO_DEPTH];
  logic [FAW-1:0] wptr, rptr;
  logic [FCW-1:0] count;

  assign qstat.full  = (count == FCW'(FIFO_DEPTH));
  assign qstat.empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0; rptr <= '0; count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

>>> hdl/sxi_back.sv
// Back end: pipelined restoring divider for t, scaling of da by t, result register.
module sxi_back (
  input  logic              clk,
  input  logic              rst,
  input  sxi_pkg::sxi_job_t head,
  input  logic              avail,
  output logic              pop,
  sxi_result_if.source      result
);
  import sxi_pkg::*;

  typedef struct packed {
    logic          crossed;
    logic          one;
    logic [SW-1:0] r;
    logic [SW-1:0] den;
    logic [TF-1:0] q;
    logic [DW-1:0] magx;
    logic          negx;
    logic [DW-1:0] magy;
    logic          negy;
    logic [CW-1:0] ax0;
    logic [CW-1:0] ay0;
  } div_t;

  logic en;
  div_t dv_in;
  div_t dv [1:TF];
  logic vld [1:TF];

  logic          mv;
  logic          m_crossed, m_negx, m_negy;
  logic [MW-1:0] m_px, m_py;
  logic [CW-1:0] m_ax0, m_ay0;
  logic [TW-1:0] tval;
  logic [CW-1:0] offx, offy;

  assign en  = !result.valid || result.ready;
  assign pop = en && avail;

  always_comb begin
    dv_in.crossed = head.crossed;
    dv_in.one     = head.one;
    dv_in.r       = head.tn;
    dv_in.den     = head.den;
    dv_in.q       = '0;
    dv_in.magx    = head.magx;
    dv_in.negx    = head.negx;
    dv_in.magy    = head.magy;
    dv_in.negy    = head.negy;
    dv_in.ax0     = head.ax0;
    dv_in.ay0     = head.ay0;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < TF; k++) begin : g_div
    div_t        cur;
    div_t        nxt;
    logic        cur_v;
    logic [SW:0] r2;
    logic        ge;

    if (k == 0) begin : g_first
      assign cur   = dv_in;
      assign cur_v = avail;
    end else begin : g_rest
      assign cur   = dv[k];
      assign cur_v = vld[k];
    end

    assign r2 = {cur.r, 1'b0};
    assign ge = (r2 >= {1'b0, cur.den});

    always_comb begin
      nxt   = cur;
      nxt.r = ge ? SW'(r2 - {1'b0, cur.den}) : SW'(r2);
      nxt.q = {cur.q[TF-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= cur_v;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[k+1] <= nxt;
      end
    end
  end

  assign tval = dv[TF].one ? TW'(1) << TF : {1'b0, dv[TF].q};

  assign offx = CW'(m_px >> TF);
  assign offy = CW'(m_py >> TF);

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      mv <= vld[TF];
      result.valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_px      <= MW'(dv[TF].magx) * MW'(tval);
      m_py      <= MW'(dv[TF].magy) * MW'(tval);
      m_crossed <= dv[TF].crossed;
      m_negx    <= dv[TF].negx;
      m_negy    <= dv[TF].negy;
      m_ax0     <= dv[TF].ax0;
      m_ay0     <= dv[TF].ay0;
      result.crossed <= m_crossed;
      if (m_crossed) begin
        result.cross_x <= m_negx ? $signed(m_ax0 - offx) : $signed(m_ax0 + offx);
        result.cross_y <= m_negy ? $signed(m_ay0 - offy) : $signed(m_ay0 + offy);
      end else begin
        result.cross_x <= '0;
        result.cross_y <= '0;
      end
    end
  end

endmodule

>>> hdl/segment_intersection_2d.sv
// Top level: 2D segment crossing test, front end, job queue and divider back end.
//
//  channel  dir  handshake     payload
//  pair     in   valid/ready   first/second segment start and end, signed Q12.12
//  result   out  valid/ready   crossed, cross_x, cross_y (Q12.12, zero if no crossing)
//
// One request per cycle while the result flows; path: 5 front stages, the queue, 24
// divider stages (one quotient bit each), one multiply stage and the result register.
// Reset (rst, synchronous) empties the pipelines and the 4-entry queue.
// A stalled result holds the back end; the queue absorbs the front end's
// in-flight requests, then pair.ready drops once the queue is full.
module segment_intersection_2d (
  input  logic          clk,
  input  logic          rst,
  sxi_pair_if.sink      pair,
  sxi_result_if.source  result
);
  import sxi_pkg::*;

  logic       push, pop;
  sxi_job_t   job_in, job_out;
  sxi_qstat_t qstat;

  // front: diffs, cross products, sign fix, range test
  sxi_front u_front (
    .clk   (clk),
    .rst   (rst),
    .pair  (pair),
    .qstat (qstat),
    .push  (push),
    .job   (job_in)
  );

  // decoupling queue
  sxi_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job_in),
    .pop   (pop),
    .rdata (job_out),
    .qstat (qstat)
  );

  // back: t = tn/den, point = a0 + da*t
  sxi_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (job_out),
    .avail  (!qstat.empty),
    .pop    (pop),
    .result (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !qstat.empty)
    else $error("queue read while empty");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.crossed) |-> (result.cross_x == '0 && result.cross_y == '0))
    else $error("non-crossing result with nonzero point");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

endmodule
